FILE: rtl/core/shtu_pkg.sv
// Shared types and constants for the scheduled hysteresis thermostat.
package shtu_pkg;

	localparam int SCHEDULE_DEPTH = 16;
	localparam int CNT_W          = $clog2(SCHEDULE_DEPTH + 1);

	localparam int TIME_W  = 12;
	localparam int TEMP_W  = 9;
	localparam int BAND_W  = 6;
	localparam int CMD_W   = 2;
	localparam int CFG_W   = 9;
	localparam int CFG_A_W = 1;
	localparam int CMP_W   = TEMP_W + 2;

	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 16;

	localparam logic signed [TEMP_W-1:0] RESET_DEFAULT_SETPOINT = 9'sd70;
	localparam logic        [BAND_W-1:0] RESET_HYSTERESIS_BAND  = 6'd2;

	localparam logic [CFG_A_W-1:0] REG_DEFAULT_SETPOINT = 1'd0;
	localparam logic [CFG_A_W-1:0] REG_HYSTERESIS_BAND  = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// control broadcast to every cell of the schedule chain
	typedef struct packed {
		logic load;   // sorted insert of the new entry
		logic rotate; // every cell takes its upper neighbour
	} cell_ctl_t;

endpackage

FILE: rtl/core/scheduled_hysteresis_thermostat_unit.sv
// Top level: schedule chain, scan sequencer and bang-bang heater control.
//
//  port group   dir  width  contents
//  s_*          in   48+2   schedule commands and ticks
//  m_*          out  16     one result per tick
//  cfg_*        in   1+9    register writes (default setpoint, band)
//
// A load or clear is taken while idle and does not hold the input. A tick's
// result is registered after the scan state has rotated the full cell chain past
// cell 0 and the done state has made the heater decision. The next item is
// taken once the sequencer is back in idle.
// The result register frees the input side: a new item is taken while a
// result still waits on m_tready. A tick only stalls in its last cycle if
// the previous result has not yet been taken.
// Reset empties the schedule, sets the setpoint to its default, heater off.
module scheduled_hysteresis_thermostat_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [11:0] entry_time, [20:12] entry_temp, [32:21] time_of_day,
	// [41:33] measured_temp, [47:42] zero
	input  logic [shtu_pkg::S_DATA_W-1:0]      s_tdata,
	// [1:0] command
	input  logic [shtu_pkg::CMD_W-1:0]         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [8:0] active_setpoint, [9] heater_on, [10] heater_commanded, [15:11] zero
	output logic [shtu_pkg::M_DATA_W-1:0]      m_tdata,
	input  logic                               cfg_wen,
	input  logic [shtu_pkg::CFG_A_W-1:0]       cfg_idx,
	input  logic [shtu_pkg::CFG_W-1:0]         cfg_data
);

	localparam int D = shtu_pkg::SCHEDULE_DEPTH;

	logic        [shtu_pkg::TIME_W-1:0] in_entry_time;
	logic signed [shtu_pkg::TEMP_W-1:0] in_entry_temp;
	logic        [shtu_pkg::TIME_W-1:0] in_now;
	logic signed [shtu_pkg::TEMP_W-1:0] in_meas;

	assign in_entry_time = s_tdata[11:0];
	assign in_entry_temp = s_tdata[20:12];
	assign in_now        = s_tdata[32:21];
	assign in_meas       = s_tdata[41:33];

	shtu_pkg::state_t state_q, state_d;

	logic [shtu_pkg::CNT_W-1:0]         count_q;
	logic [shtu_pkg::CNT_W-1:0]         scan_q;
	logic [shtu_pkg::TIME_W-1:0]        now_q;
	logic signed [shtu_pkg::TEMP_W-1:0] meas_q;
	logic [shtu_pkg::BAND_W-1:0]        band_q;
	logic signed [shtu_pkg::TEMP_W-1:0] setpoint_q;
	logic                               matched_q;
	logic                               heater_q;
	logic                               m_tvalid_q;
	logic [shtu_pkg::M_DATA_W-1:0]      m_tdata_q;

	logic in_xfer;
	logic do_load;
	logic do_clear;
	logic do_tick;
	logic out_free;
	logic finish;

	shtu_pkg::cell_ctl_t ctl;

	logic        [shtu_pkg::TIME_W-1:0] c_time [D];
	logic signed [shtu_pkg::TEMP_W-1:0] c_temp [D];
	logic                               c_keep [D];

	assign s_tready = (state_q == shtu_pkg::ST_IDLE);
	assign in_xfer  = s_tvalid && s_tready;
	assign do_load  = in_xfer && (s_tuser == shtu_pkg::CMD_LOAD) &&
	                  (count_q < shtu_pkg::CNT_W'(D));
	assign do_clear = in_xfer && (s_tuser == shtu_pkg::CMD_CLEAR);
	assign do_tick  = in_xfer && (s_tuser == shtu_pkg::CMD_TICK);
	assign out_free = !m_tvalid_q || m_tready;

	assign ctl.load   = do_load;
	assign ctl.rotate = (state_q == shtu_pkg::ST_SCAN);

	for (genvar i = 0; i < D; i++) begin : g_cell
		logic occ;
		logic                               p_keep;
		logic        [shtu_pkg::TIME_W-1:0] p_time;
		logic signed [shtu_pkg::TEMP_W-1:0] p_temp;

		assign occ = (count_q > shtu_pkg::CNT_W'(i));

		if (i == 0) begin : g_head
			assign p_keep = 1'b1;
			assign p_time = in_entry_time;
			assign p_temp = in_entry_temp;
		end else begin : g_body
			assign p_keep = c_keep[i-1];
			assign p_time = c_time[i-1];
			assign p_temp = c_temp[i-1];
		end

		shtu_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occ),
			.new_time  (in_entry_time),
			.new_temp  (in_entry_temp),
			.prev_keep (p_keep),
			.prev_time (p_time),
			.prev_temp (p_temp),
			.next_time (c_time[(i + 1) % D]),
			.next_temp (c_temp[(i + 1) % D]),
			.keep      (c_keep[i]),
			.cell_time (c_time[i]),
			.cell_temp (c_temp[i])
		);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= shtu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		finish  = 1'b0;
		case (state_q)
			shtu_pkg::ST_IDLE: begin
				if (do_tick) state_d = shtu_pkg::ST_SCAN;
			end
			shtu_pkg::ST_SCAN: begin
				if (scan_q == shtu_pkg::CNT_W'(D - 1)) state_d = shtu_pkg::ST_DONE;
			end
			shtu_pkg::ST_DONE: begin
				if (out_free) begin
					finish  = 1'b1;
					state_d = shtu_pkg::ST_IDLE;
				end
			end
			default: state_d = shtu_pkg::ST_IDLE;
		endcase
	end

	// bang-bang thresholds, widened so that sum and difference never wrap
	logic signed [shtu_pkg::CMP_W-1:0] sp_w, band_w, meas_w, hi_w, lo_w;
	logic turn_off, turn_on, heater_d;

	assign sp_w     = shtu_pkg::CMP_W'(setpoint_q);
	assign band_w   = $signed({{(shtu_pkg::CMP_W - shtu_pkg::BAND_W){1'b0}}, band_q});
	assign meas_w   = shtu_pkg::CMP_W'(meas_q);
	assign hi_w     = sp_w + band_w;
	assign lo_w     = sp_w - band_w;
	assign turn_off = (hi_w <= meas_w);
	assign turn_on  = !turn_off && (lo_w >= meas_w);
	assign heater_d = turn_off ? 1'b0 : (turn_on ? 1'b1 : heater_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_q     <= '0;
			band_q     <= shtu_pkg::RESET_HYSTERESIS_BAND;
			setpoint_q <= shtu_pkg::RESET_DEFAULT_SETPOINT;
			matched_q  <= 1'b0;
			heater_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_idx)
					shtu_pkg::REG_DEFAULT_SETPOINT: begin
						if (!matched_q) setpoint_q <= cfg_data;
					end
					shtu_pkg::REG_HYSTERESIS_BAND: band_q <= cfg_data[shtu_pkg::BAND_W-1:0];
					default: ;
				endcase
			end

			if (do_load) count_q <= count_q + 1'b1;
			else if (do_clear) count_q <= '0;

			if (do_tick) scan_q <= '0;
			else if (state_q == shtu_pkg::ST_SCAN) scan_q <= scan_q + 1'b1;

			// cell 0 holds entry scan_q during the rotation; later matches win
			if (state_q == shtu_pkg::ST_SCAN && scan_q < count_q && now_q >= c_time[0]) begin
				setpoint_q <= c_temp[0];
				matched_q  <= 1'b1;
			end

			if (finish) begin
				heater_q   <= heater_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_tick) begin
			now_q  <= in_now;
			meas_q <= in_meas;
		end
		if (finish) begin
			m_tdata_q <= {5'd0, (turn_off || turn_on), heater_d, setpoint_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= shtu_pkg::CNT_W'(D))
		else $error("schedule count beyond depth");

	a_tick_scan: assert property (@(posedge clk) disable iff (!arst_n)
		do_tick |=> (state_q == shtu_pkg::ST_SCAN && scan_q == '0))
		else $error("tick did not start a scan");

	a_scan_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == shtu_pkg::ST_SCAN && scan_q == shtu_pkg::CNT_W'(D - 1))
		|=> (state_q == shtu_pkg::ST_DONE))
		else $error("scan did not end after a full rotation");

	a_result_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !$past(m_tvalid)) |-> $past(state_q == shtu_pkg::ST_DONE))
		else $error("result raised outside tick completion");

endmodule

FILE: rtl/core/shtu_cell.sv
// One schedule slot of the sorted chain: holds a time and a temperature.
module shtu_cell (
	input  logic                                   clk,
	input  shtu_pkg::cell_ctl_t                    ctl,
	input  logic                                   occupied,
	input  logic        [shtu_pkg::TIME_W-1:0]     new_time,
	input  logic signed [shtu_pkg::TEMP_W-1:0]     new_temp,
	input  logic                                   prev_keep,
	input  logic        [shtu_pkg::TIME_W-1:0]     prev_time,
	input  logic signed [shtu_pkg::TEMP_W-1:0]     prev_temp,
	input  logic        [shtu_pkg::TIME_W-1:0]     next_time,
	input  logic signed [shtu_pkg::TEMP_W-1:0]     next_temp,
	output logic                                   keep,
	output logic        [shtu_pkg::TIME_W-1:0]     cell_time,
	output logic signed [shtu_pkg::TEMP_W-1:0]     cell_temp
);

	logic        [shtu_pkg::TIME_W-1:0] time_q;
	logic signed [shtu_pkg::TEMP_W-1:0] temp_q;

	// entries at or before the new time stay; ties keep the older entry first
	assign keep      = occupied && (time_q <= new_time);
	assign cell_time = time_q;
	assign cell_temp = temp_q;

	always_ff @(posedge clk) begin
		if (ctl.rotate) begin
			time_q <= next_time;
			temp_q <= next_temp;
		end else if (ctl.load && !keep) begin
			if (prev_keep) begin
				time_q <= new_time;
				temp_q <= new_temp;
			end else begin
				time_q <= prev_time;
				temp_q <= prev_temp;
			end
		end
	end

endmodule
